// ===== hw/rtl/plb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_pkg
// Types shared by the price level book update core and its submodules.
// ----------------------------------------------------------------------------
package plb_pkg;

    localparam int PX_W  = 48;
    localparam int QIN_W = 48;
    localparam int QTY_W = 47;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef struct packed {
        logic                    snapshot_start;
        logic                    side;
        logic [PX_W-1:0]         price;
        logic signed [QIN_W-1:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic             bid_valid;
        logic [PX_W-1:0]  best_bid_price;
        logic [QTY_W-1:0] best_bid_qty;
        logic             ask_valid;
        logic [PX_W-1:0]  best_ask_price;
        logic [QTY_W-1:0] best_ask_qty;
        logic             not_crossed;
        logic             overflow;
    } t_out_item;

    // Classified event as it waits in the queue.
    typedef struct packed {
        logic             snap;
        logic             side;
        logic             remove;
        logic [PX_W-1:0]  price;
        logic [QTY_W-1:0] qty;
    } t_cmd;

    // Top of one side of the book.
    typedef struct packed {
        logic             valid;
        logic [PX_W-1:0]  price;
        logic [QTY_W-1:0] qty;
    } t_side_top;

endpackage

// ===== hw/rtl/plb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_front
// Accepts events, classifies them as delete or insert/overwrite, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module plb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  plb_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output plb_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import plb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cls;

    assign o_busy      = (r_cnt == 2'd2);
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    // A quantity of zero or with the sign bit set deletes the level.
    always_comb begin
        cls.snap   = i_item.snapshot_start;
        cls.side   = i_item.side;
        cls.remove = (i_item.quantity == '0) || i_item.quantity[QIN_W-1];
        cls.price  = i_item.price;
        cls.qty    = i_item.quantity[QTY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/plb_side.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_side
// One side of the book as a row of sorted level cells. Every cell compares
// its price with the event price and shifts, loads or holds.
// ----------------------------------------------------------------------------
module plb_side #(
    parameter int LEVELS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_is_ask,
    input  logic                        i_apply,
    input  logic                        i_clear,
    input  logic                        i_remove,
    input  logic [plb_pkg::PX_W-1:0]    i_price,
    input  logic [plb_pkg::QTY_W-1:0]   i_qty,
    output plb_pkg::t_side_top          o_top,
    output logic                        o_dropped
);
    import plb_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);

    logic [PX_W-1:0]  r_px [LEVELS];
    logic [QTY_W-1:0] r_qt [LEVELS];
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [CW-1:0]    base_cnt;

    logic [LEVELS-1:0] vld;
    logic [LEVELS-1:0] ahead;
    logic [LEVELS-1:0] hit;
    logic              any_hit;
    logic              full;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            vld[i]   = !i_clear && (CW'(i) < r_cnt);
            ahead[i] = vld[i] && (i_is_ask ? (r_px[i] < i_price) : (r_px[i] > i_price));
            hit[i]   = vld[i] && (r_px[i] == i_price);
        end
    end

    assign any_hit   = |hit;
    assign full      = !i_clear && (r_cnt == CW'(LEVELS));
    assign o_dropped = i_apply && !i_remove && !any_hit && full;
    assign base_cnt  = i_clear ? '0 : r_cnt;

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_apply) begin
                if (i_remove) begin
                    if (g < LEVELS - 1) begin
                        if (any_hit && !ahead[g]) begin
                            r_px[g] <= r_px[(g + 1) % LEVELS];
                            r_qt[g] <= r_qt[(g + 1) % LEVELS];
                        end
                    end
                end else if (any_hit) begin
                    if (hit[g]) begin
                        r_qt[g] <= i_qty;
                    end
                end else if (!ahead[g]) begin
                    // The first cell not ahead of the new price takes it.
                    if (g == 0 || ahead[(g + LEVELS - 1) % LEVELS]) begin
                        r_px[g] <= i_price;
                        r_qt[g] <= i_qty;
                    end else begin
                        r_px[g] <= r_px[(g + LEVELS - 1) % LEVELS];
                        r_qt[g] <= r_qt[(g + LEVELS - 1) % LEVELS];
                    end
                end
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_apply) begin
            n_cnt = base_cnt;
            if (i_remove && any_hit) begin
                n_cnt = base_cnt - CW'(1);
            end else if (!i_remove && !any_hit && !full) begin
                n_cnt = base_cnt + CW'(1);
            end
        end else if (i_clear) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        o_top.valid = (r_cnt != '0);
        o_top.price = o_top.valid ? r_px[0] : '0;
        o_top.qty   = o_top.valid ? r_qt[0] : '0;
    end

endmodule

// ===== hw/rtl/plb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_back
// Takes classified events from the queue, applies them to the bid and ask
// level tables, and reports the top of the book in the following cycle.
// ----------------------------------------------------------------------------
module plb_back #(
    parameter int LEVELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  plb_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    output plb_pkg::t_out_item o_result
);
    import plb_pkg::*;

    localparam logic ST_RUN    = 1'b0;
    localparam logic ST_REPORT = 1'b1;

    logic      r_state;
    logic      r_ovf;
    logic      apply;
    logic      bid_drop;
    logic      ask_drop;
    t_side_top bid_top;
    t_side_top ask_top;

    assign apply     = (r_state == ST_RUN) && i_cmd_valid;
    assign o_cmd_pop = apply;

    plb_side #(.LEVELS(LEVELS)) u_bid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_ask  (SIDE_BID),
        .i_apply   (apply && (i_cmd.side == SIDE_BID)),
        .i_clear   (apply && i_cmd.snap),
        .i_remove  (i_cmd.remove),
        .i_price   (i_cmd.price),
        .i_qty     (i_cmd.qty),
        .o_top     (bid_top),
        .o_dropped (bid_drop)
    );

    plb_side #(.LEVELS(LEVELS)) u_ask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_ask  (SIDE_ASK),
        .i_apply   (apply && (i_cmd.side == SIDE_ASK)),
        .i_clear   (apply && i_cmd.snap),
        .i_remove  (i_cmd.remove),
        .i_price   (i_cmd.price),
        .i_qty     (i_cmd.qty),
        .o_top     (ask_top),
        .o_dropped (ask_drop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            case (r_state)
                ST_RUN:    r_state <= apply ? ST_REPORT : ST_RUN;
                ST_REPORT: r_state <= ST_RUN;
                default:   r_state <= ST_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_ovf <= bid_drop || ask_drop;
        end
    end

    assign o_valid = (r_state == ST_REPORT);

    always_comb begin
        o_result.bid_valid      = bid_top.valid;
        o_result.best_bid_price = bid_top.price;
        o_result.best_bid_qty   = bid_top.qty;
        o_result.ask_valid      = ask_top.valid;
        o_result.best_ask_price = ask_top.price;
        o_result.best_ask_qty   = ask_top.qty;
        o_result.not_crossed    = !bid_top.valid || !ask_top.valid
                                  || (bid_top.price < ask_top.price);
        o_result.overflow       = r_ovf;
    end

endmodule

// ===== hw/rtl/price_level_book_update_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_update_core
// Two-sided level-2 price book: bid and ask tables kept sorted in cell rows.
//
// An event transfers in at a rising edge where i_start is high and o_busy is
// low. It carries a snapshot mark, a side, a price and a signed quantity.
// A two-entry queue sits in front of the update engine, so o_busy rises only
// when two events are waiting.
// Each event yields one result on o_result, marked by o_valid for exactly
// one cycle; the receiver must take it then. An event accepted into an
// empty queue is first held in the queue register, then popped and applied
// to the level tables as the engine enters its report state, in which
// o_valid is high. Each event takes a run state, for the parallel compare
// and shift across all level cells of a side, then a report state to
// present the top of book; no new event is popped in the report state.
// Reset empties both tables and the queue; level contents are not cleared,
// only the level counts.
// ----------------------------------------------------------------------------
module price_level_book_update_core #(
    parameter int LEVELS_PER_SIDE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  plb_pkg::t_in_item  i_item,
    output logic               o_valid,
    output plb_pkg::t_out_item o_result
);
    import plb_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    plb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    plb_back #(.LEVELS(LEVELS_PER_SIDE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // A pop only ever takes a queued event.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    // Every pop yields exactly one result in the next cycle.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |=> o_valid)
        else $error("result missing after event");

    // Results never come in adjacent cycles.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results in adjacent cycles");

    // No event is popped while a result is being shown.
    a_no_pop_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !cmd_pop)
        else $error("pop during result cycle");

endmodule

// ===== tb/sv/price_level_book_update_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_update_core_tb
// Drives book events into the price level book core, keeps a behavioral book
// of both sides, and compares each top-of-book result with the predicted one.
// ----------------------------------------------------------------------------
module price_level_book_update_core_tb;
    import plb_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_result;

    price_level_book_update_core #(.LEVELS_PER_SIDE(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    // Behavioral book: index 0 is the best level of each side.
    logic [PX_W-1:0]  book_px  [2][DEPTH];
    logic [QTY_W-1:0] book_qty [2][DEPTH];
    int               book_cnt [2];
    t_out_item        top_queue[$];
    int               err_cnt;
    int               cycle_cnt;
    int               send_idle_pct;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit ahead(logic [PX_W-1:0] a, logic [PX_W-1:0] b, bit ask);
        return ask ? (a < b) : (a > b);
    endfunction

    function automatic t_out_item apply_event(t_in_item it);
        t_out_item r;
        int        s;
        int        n;
        int        pos;
        int        last;
        bit        hit;
        bit        del;
        bit        drop;
        s = int'(it.side);
        del = (it.quantity <= 0);
        drop = 1'b0;
        if (it.snapshot_start) begin
            book_cnt[0] = 0;
            book_cnt[1] = 0;
        end
        n = book_cnt[s];
        pos = 0;
        while (pos < n && ahead(book_px[s][pos], it.price, s == SIDE_ASK)) pos++;
        hit = (pos < n) && (book_px[s][pos] == it.price);
        if (del) begin
            if (hit) begin
                for (int i = pos; i + 1 < n; i++) begin
                    book_px[s][i] = book_px[s][i+1];
                    book_qty[s][i] = book_qty[s][i+1];
                end
                book_cnt[s] = n - 1;
            end
        end else if (hit) begin
            book_qty[s][pos] = it.quantity[QTY_W-1:0];
        end else begin
            last = n;
            if (n >= DEPTH) begin
                drop = 1'b1;
                last = DEPTH - 1;
            end else begin
                book_cnt[s] = n + 1;
            end
            if (pos < DEPTH) begin
                for (int i = last; i > pos; i--) begin
                    book_px[s][i] = book_px[s][i-1];
                    book_qty[s][i] = book_qty[s][i-1];
                end
                book_px[s][pos] = it.price;
                book_qty[s][pos] = it.quantity[QTY_W-1:0];
            end
        end
        r = '0;
        r.bid_valid = book_cnt[0] > 0;
        r.ask_valid = book_cnt[1] > 0;
        if (r.bid_valid) begin
            r.best_bid_price = book_px[0][0];
            r.best_bid_qty = book_qty[0][0];
        end
        if (r.ask_valid) begin
            r.best_ask_price = book_px[1][0];
            r.best_ask_qty = book_qty[1][0];
        end
        r.not_crossed = !r.bid_valid || !r.ask_valid ||
                        (r.best_bid_price < r.best_ask_price);
        r.overflow = drop;
        return r;
    endfunction

    // Sends one event; the expectation is queued at the accepting edge.
    // i_start stays high after the transfer so that the next event can follow
    // without a gap; idle cycles and the final drain lower it.
    task automatic send_event(t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        top_queue = {top_queue, apply_event(it)};
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (top_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                err_cnt++;
            end else begin
                want = top_queue.pop_front();
                if (o_result !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, o_result);
                    err_cnt++;
                end
            end
        end
    end

    function automatic t_in_item mk(bit snap, bit side, logic [PX_W-1:0] px,
                                    logic signed [QIN_W-1:0] q);
        t_in_item it;
        it.snapshot_start = snap;
        it.side = side;
        it.price = px;
        it.quantity = q;
        return it;
    endfunction

    function automatic logic [PX_W-1:0] rand_px();
        case ($urandom_range(3, 0))
            0: return PX_W'({$urandom, $urandom});
            1: return PX_W'($urandom_range(80, 0));
            default: return PX_W'(1000 + $urandom_range(100, 0));
        endcase
    endfunction

    function automatic logic signed [QIN_W-1:0] rand_qty();
        logic [QIN_W-1:0] v;
        v = QIN_W'({$urandom, $urandom});
        case ($urandom_range(9, 0))
            0: return '0;
            1: return {1'b1, v[QIN_W-2:0]};
            2: return {1'b0, {(QIN_W-1){1'b1}}};
            default: return {1'b0, v[QIN_W-2:0]};
        endcase
    endfunction

    task automatic test_directed();
        send_event(mk(1'b0, SIDE_BID, 48'd100, 48'sd5));
        send_event(mk(1'b0, SIDE_ASK, 48'd200, 48'sd7));
        send_event(mk(1'b0, SIDE_BID, {PX_W{1'b1}}, {1'b0, {47{1'b1}}}));
        send_event(mk(1'b0, SIDE_ASK, '0, 48'sd1));
        send_event(mk(1'b0, SIDE_BID, 48'd100, 48'sd9));
        send_event(mk(1'b0, SIDE_BID, 48'd555, 48'sd0));
        send_event(mk(1'b0, SIDE_BID, {PX_W{1'b1}}, {1'b1, 47'd0}));
        send_event(mk(1'b0, SIDE_ASK, '0, -48'sd1));
        send_event(mk(1'b1, SIDE_ASK, 48'd200, 48'sd0));
        send_event(mk(1'b1, SIDE_BID, 48'd10, 48'sd3));
        send_event(mk(1'b0, SIDE_ASK, 48'd5, 48'sd4));
    endtask

    // Fill one side past its depth, with better, worse and overwrite events.
    task automatic test_full_side(bit side);
        send_event(mk(1'b1, side, 48'd1000, 48'sd1));
        for (int i = 1; i < DEPTH + 4; i++) begin
            send_event(mk(1'b0, side, PX_W'(1000 + 2 * i), QIN_W'(i + 1)));
        end
        send_event(mk(1'b0, side, 48'd999, 48'sd77));
        send_event(mk(1'b0, side, 48'd5000, 48'sd78));
        send_event(mk(1'b0, side, 48'd1010, 48'sd79));
        send_event(mk(1'b0, side, 48'd1011, 48'sd80));
    endtask

    task automatic test_random(int n);
        bit side;
        for (int i = 0; i < n; i++) begin
            side = 1'($urandom_range(1, 0));
            send_event(mk($urandom_range(60, 0) == 0, side, rand_px(), rand_qty()));
        end
    endtask

    task automatic wait_drain();
        i_start <= 1'b0;
        while (top_queue.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        send_idle_pct = 10;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_side(SIDE_BID);
        test_full_side(SIDE_ASK);
        test_random(550);
        send_idle_pct = 88;
        test_random(450);
        send_idle_pct = 0;
        test_random(550);
        wait_drain();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
